// ===== rtl/tcc_pkg.sv =====
// Shared types and constants of the text console cursor engine.
// Holds the command format passed from the front end, through the queue,
// to the back end. No dependencies.
package tcc_pkg;

    localparam int LINE_WIDTH_DEF    = 80;
    localparam int SCREEN_CELLS_DEF  = 2000;
    localparam int CONSOLES_DEF      = 4;
    localparam int CONSOLE_CELLS_DEF = 4096;
    localparam int QUEUE_DEPTH_DEF   = 2;

    // The console index field is two bits wide, so at most four consoles are reachable.
    localparam int SLOTS  = 4;
    localparam int ADDR_W = 14;

    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] ATTR_RESET     = 8'h07;

    localparam logic [1:0] REQ_PUT         = 2'd0;
    localparam logic [1:0] REQ_SCROLL_UP   = 2'd1;
    localparam logic [1:0] REQ_SCROLL_DOWN = 2'd2;
    localparam logic [1:0] REQ_SELECT      = 2'd3;

    typedef enum logic [2:0] {
        OP_GLYPH,
        OP_NEWLINE,
        OP_BACKSPACE,
        OP_SCROLL_UP,
        OP_SCROLL_DOWN,
        OP_SELECT,
        OP_IGNORE
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] console;
        logic [7:0] glyph;
    } cmd_t;

endpackage

// ===== rtl/tcc_front.sv =====
// Front end of the text console cursor engine: takes request beats and
// classifies them into commands for the queue. Depends on tcc_pkg.
module tcc_front #(
    parameter int CONSOLES = tcc_pkg::CONSOLES_DEF
) (
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [1:0]   s_req_type,
    input  logic [1:0]   s_console_index,
    input  logic [7:0]   s_char_code,
    input  logic         queue_full,
    output logic         queue_push,
    output tcc_pkg::cmd_t queue_cmd
);
    import tcc_pkg::*;

    assign s_ready    = !queue_full;
    assign queue_push = s_valid && !queue_full;

    always_comb begin
        queue_cmd.console = s_console_index;
        queue_cmd.glyph   = s_char_code;
        queue_cmd.op      = OP_IGNORE;
        unique case (s_req_type)
            REQ_PUT: begin
                case (s_char_code)
                    CHAR_NEWLINE:   queue_cmd.op = OP_NEWLINE;
                    CHAR_BACKSPACE: queue_cmd.op = OP_BACKSPACE;
                    default:        queue_cmd.op = OP_GLYPH;
                endcase
            end
            REQ_SCROLL_UP:   queue_cmd.op = OP_SCROLL_UP;
            REQ_SCROLL_DOWN: queue_cmd.op = OP_SCROLL_DOWN;
            REQ_SELECT:      queue_cmd.op = OP_SELECT;
            default:         queue_cmd.op = OP_IGNORE;
        endcase
        // A console beyond the configured count leaves all state alone.
        if (int'(s_console_index) >= CONSOLES) begin
            queue_cmd.op = OP_IGNORE;
        end
    end

endmodule

// ===== rtl/tcc_queue.sv =====
// Short command queue between the front and back ends.
// Register based, one push and one pop per cycle. Depends on tcc_pkg.
module tcc_queue #(
    parameter int DEPTH = tcc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  tcc_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output tcc_pkg::cmd_t pop_cmd
);
    import tcc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/tcc_back.sv =====
// Back end of the text console cursor engine: per-console cursor and view
// tables, command execution, view follow loop and the result register.
// Depends on tcc_pkg.
module tcc_back #(
    parameter int LINE_WIDTH    = tcc_pkg::LINE_WIDTH_DEF,
    parameter int SCREEN_CELLS  = tcc_pkg::SCREEN_CELLS_DEF,
    parameter int CONSOLE_CELLS = tcc_pkg::CONSOLE_CELLS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       queue_valid,
    input  tcc_pkg::cmd_t              queue_cmd,
    output logic                       queue_pop,
    input  logic [7:0]                 char_attr,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_mem_write,
    output logic [tcc_pkg::ADDR_W-1:0] m_mem_addr,
    output logic [7:0]                 m_mem_char,
    output logic [7:0]                 m_mem_attr,
    output logic [tcc_pkg::ADDR_W-1:0] m_cursor_pos,
    output logic [tcc_pkg::ADDR_W-1:0] m_view_start,
    output logic                       m_is_current
);
    import tcc_pkg::*;

    localparam int POS_W = $clog2(SLOTS * CONSOLE_CELLS + SCREEN_CELLS + LINE_WIDTH + 1);
    localparam int COL_W = $clog2(LINE_WIDTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FOLLOW,
        ST_RESULT
    } state_t;

    state_t           state_reg;
    cmd_t             cmd_reg;
    logic [POS_W-1:0] cursor_reg [SLOTS];
    logic [POS_W-1:0] view_reg   [SLOTS];
    logic [COL_W-1:0] col_reg    [SLOTS];
    logic [1:0]       current_reg;
    logic             wr_reg;
    logic [POS_W-1:0] waddr_reg;
    logic [7:0]       wchar_reg;

    logic              m_valid_reg;
    logic              m_mem_write_reg;
    logic [ADDR_W-1:0] m_mem_addr_reg;
    logic [7:0]        m_mem_char_reg;
    logic [7:0]        m_mem_attr_reg;
    logic [ADDR_W-1:0] m_cursor_pos_reg;
    logic [ADDR_W-1:0] m_view_start_reg;
    logic              m_is_current_reg;

    logic [1:0]       con;
    logic [POS_W-1:0] cur;
    logic [POS_W-1:0] view;
    logic [COL_W-1:0] col;
    logic [POS_W-1:0] base;
    logic [POS_W-1:0] slice_end;
    logic [POS_W-1:0] view_bottom;
    logic [POS_W-1:0] cur_dec;
    logic [COL_W-1:0] col_inc;
    logic [COL_W-1:0] col_dec;
    logic             can_down;
    logic             need_follow;
    logic             can_put;
    logic             can_newline;
    logic             can_backspace;
    logic             out_free;

    // Every access works on the console of the command being executed.
    assign con         = cmd_reg.console;
    assign cur         = cursor_reg[con];
    assign view        = view_reg[con];
    assign col         = col_reg[con];
    assign base        = POS_W'(con) * POS_W'(CONSOLE_CELLS);
    assign slice_end   = base + POS_W'(CONSOLE_CELLS);
    assign view_bottom = view + POS_W'(SCREEN_CELLS);
    assign cur_dec     = cur - POS_W'(1);
    assign col_inc     = (col == COL_W'(LINE_WIDTH - 1)) ? '0 : col + 1'b1;
    assign col_dec     = (col == '0) ? COL_W'(LINE_WIDTH - 1) : col - 1'b1;

    assign can_down      = view_bottom < slice_end;
    assign need_follow   = (cur >= view_bottom) && can_down;
    assign can_put       = (cur + POS_W'(1)) < slice_end;
    assign can_newline   = (cur + POS_W'(LINE_WIDTH)) < slice_end;
    assign can_backspace = cur > base;

    assign out_free  = !m_valid_reg || m_ready;
    assign queue_pop = (state_reg == ST_IDLE) && queue_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            current_reg <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                cursor_reg[i] <= POS_W'(i) * POS_W'(CONSOLE_CELLS);
                view_reg[i]   <= POS_W'(i) * POS_W'(CONSOLE_CELLS);
                col_reg[i]    <= '0;
            end
        end else begin
            // The result state sets the valid flag itself when it loads a beat.
            if (m_valid_reg && m_ready && state_reg != ST_RESULT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (queue_valid) begin
                        cmd_reg   <= queue_cmd;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    wr_reg    <= 1'b0;
                    waddr_reg <= cur;
                    wchar_reg <= cmd_reg.glyph;
                    state_reg <= ST_RESULT;
                    case (cmd_reg.op)
                        OP_GLYPH: begin
                            // The last cell of the slice is never written.
                            if (can_put) begin
                                wr_reg          <= 1'b1;
                                cursor_reg[con] <= cur + POS_W'(1);
                                col_reg[con]    <= col_inc;
                            end
                            state_reg <= ST_FOLLOW;
                        end
                        OP_NEWLINE: begin
                            if (can_newline) begin
                                cursor_reg[con] <= cur - POS_W'(col) + POS_W'(LINE_WIDTH);
                                col_reg[con]    <= '0;
                            end
                            state_reg <= ST_FOLLOW;
                        end
                        OP_BACKSPACE: begin
                            if (can_backspace) begin
                                wr_reg          <= 1'b1;
                                waddr_reg       <= cur_dec;
                                wchar_reg       <= CHAR_SPACE;
                                cursor_reg[con] <= cur_dec;
                                col_reg[con]    <= col_dec;
                            end
                            state_reg <= ST_FOLLOW;
                        end
                        OP_SCROLL_UP: begin
                            if (view > base) begin
                                view_reg[con] <= view - POS_W'(LINE_WIDTH);
                            end
                        end
                        OP_SCROLL_DOWN: begin
                            if (can_down) begin
                                view_reg[con] <= view + POS_W'(LINE_WIDTH);
                            end
                        end
                        OP_SELECT: begin
                            current_reg <= con;
                        end
                        default: begin
                        end
                    endcase
                end
                ST_FOLLOW: begin
                    // One line per cycle until the cursor is on screen or the
                    // view reaches the bottom of the slice.
                    if (need_follow) begin
                        view_reg[con] <= view + POS_W'(LINE_WIDTH);
                    end else begin
                        state_reg <= ST_RESULT;
                    end
                end
                ST_RESULT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                        if (cmd_reg.op == OP_IGNORE) begin
                            m_mem_write_reg  <= 1'b0;
                            m_mem_addr_reg   <= '0;
                            m_mem_char_reg   <= '0;
                            m_mem_attr_reg   <= '0;
                            m_cursor_pos_reg <= '0;
                            m_view_start_reg <= '0;
                            m_is_current_reg <= 1'b0;
                        end else begin
                            m_mem_write_reg  <= wr_reg;
                            m_mem_addr_reg   <= wr_reg ? waddr_reg[ADDR_W-1:0] : '0;
                            m_mem_char_reg   <= wr_reg ? wchar_reg : '0;
                            m_mem_attr_reg   <= wr_reg ? char_attr : '0;
                            m_cursor_pos_reg <= cur[ADDR_W-1:0];
                            m_view_start_reg <= view[ADDR_W-1:0];
                            m_is_current_reg <= (con == current_reg);
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_mem_write  = m_mem_write_reg;
    assign m_mem_addr   = m_mem_addr_reg;
    assign m_mem_char   = m_mem_char_reg;
    assign m_mem_attr   = m_mem_attr_reg;
    assign m_cursor_pos = m_cursor_pos_reg;
    assign m_view_start = m_view_start_reg;
    assign m_is_current = m_is_current_reg;

endmodule

// ===== rtl/text_console_cursor_engine.sv =====
// An accepted request beat goes into the queue; the back end pops it in its idle state,
// executes it, for a put walks the view down one line per cycle as needed, and then
// loads the result register once the result channel is free. The back end sequencer runs
// one command at a time, so it takes a new request only after the last result is loaded.
// Reset (aresetn, synchronous, active low): cursors and views go to each slice base,
// console 0 is current, the attribute is 0x07, and the queue and result are empty.
module text_console_cursor_engine #(
    parameter int LINE_WIDTH    = tcc_pkg::LINE_WIDTH_DEF,
    parameter int SCREEN_CELLS  = tcc_pkg::SCREEN_CELLS_DEF,
    parameter int CONSOLES      = tcc_pkg::CONSOLES_DEF,
    parameter int CONSOLE_CELLS = tcc_pkg::CONSOLE_CELLS_DEF,
    parameter int QUEUE_DEPTH   = tcc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // Attribute register write channel.
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [7:0]                 cfg_data,
    // Request channel.
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_req_type,
    input  logic [1:0]                 s_console_index,
    input  logic [7:0]                 s_char_code,
    // Result channel.
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_mem_write,
    output logic [tcc_pkg::ADDR_W-1:0] m_mem_addr,
    output logic [7:0]                 m_mem_char,
    output logic [7:0]                 m_mem_attr,
    output logic [tcc_pkg::ADDR_W-1:0] m_cursor_pos,
    output logic [tcc_pkg::ADDR_W-1:0] m_view_start,
    output logic                       m_is_current
);
    import tcc_pkg::*;

    logic       char_attr_reg;
    logic [7:0] char_attr_q_reg;
    logic       queue_full;
    logic       queue_push;
    logic       queue_pop;
    logic       queue_valid;
    cmd_t       push_cmd;
    cmd_t       pop_cmd;

    // The attribute register takes a write beat in any cycle. The user must write it
    // only while the engine is idle so a command never sees it change; this is not enforced.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_attr_reg   <= 1'b0;
            char_attr_q_reg <= ATTR_RESET;
        end else if (cfg_valid) begin
            char_attr_reg   <= 1'b1;
            char_attr_q_reg <= cfg_data;
        end
    end

    // The front end classifies each beat into a command: glyph, newline,
    // backspace, scroll, select, or ignore for a console outside the set.
    tcc_front #(
        .CONSOLES (CONSOLES)
    ) u_front (
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_console_index (s_console_index),
        .s_char_code     (s_char_code),
        .queue_full      (queue_full),
        .queue_push      (queue_push),
        .queue_cmd       (push_cmd)
    );

    // The queue lets the requester run ahead while the back end is busy
    // following the cursor or waiting on a stalled result.
    tcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (queue_push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_valid),
        .pop_cmd   (pop_cmd)
    );

    // The back end owns the cursor and view tables and the result register.
    // A put updates the cursor, then the view walks down a line per cycle
    // until the cursor is visible or the slice bottom is reached.
    tcc_back #(
        .LINE_WIDTH    (LINE_WIDTH),
        .SCREEN_CELLS  (SCREEN_CELLS),
        .CONSOLE_CELLS (CONSOLE_CELLS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .queue_valid  (queue_valid),
        .queue_cmd    (pop_cmd),
        .queue_pop    (queue_pop),
        .char_attr    (char_attr_reg ? char_attr_q_reg : ATTR_RESET),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_mem_write  (m_mem_write),
        .m_mem_addr   (m_mem_addr),
        .m_mem_char   (m_mem_char),
        .m_mem_attr   (m_mem_attr),
        .m_cursor_pos (m_cursor_pos),
        .m_view_start (m_view_start),
        .m_is_current (m_is_current)
    );

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for text_console_cursor_engine: it drives request beats,
// predicts each console update and compares every result beat field by field.
// Depends on tcc_pkg and the engine RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tcc_pkg::*;

    // The engine is built with its default geometry, and the predictor uses the same numbers.
    localparam int LINE_WIDTH    = LINE_WIDTH_DEF;
    localparam int SCREEN_CELLS  = SCREEN_CELLS_DEF;
    localparam int CONSOLES      = CONSOLES_DEF;
    localparam int CONSOLE_CELLS = CONSOLE_CELLS_DEF;

    // A put can move the view down by about 27 lines, one line per cycle, on top of its
    // other back end states. This margin covers that after the last result.
    localparam int SETTLE_CYCLES = 40;

    // One result beat: the video memory write and the state of the addressed console.
    typedef struct packed {
        logic              mem_write;
        logic [ADDR_W-1:0] mem_addr;
        logic [7:0]        mem_char;
        logic [7:0]        mem_attr;
        logic [ADDR_W-1:0] cursor_pos;
        logic [ADDR_W-1:0] view_start;
        logic              is_current;
    } console_update_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [7:0]        cfg_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [1:0]        s_req_type = '0;
    logic [1:0]        s_console_index = '0;
    logic [7:0]        s_char_code = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_mem_write;
    logic [ADDR_W-1:0] m_mem_addr;
    logic [7:0]        m_mem_char;
    logic [7:0]        m_mem_attr;
    logic [ADDR_W-1:0] m_cursor_pos;
    logic [ADDR_W-1:0] m_view_start;
    logic              m_is_current;

    // Shadow copy of the engine state, kept as absolute word positions.
    int              cursor_tbl[SLOTS];
    int              view_tbl[SLOTS];
    int              shown_console;
    logic [7:0]      attr_reg;

    console_update_t pending_updates[$];
    int              fail_count = 0;
    bit              idle_enable = 1'b1;
    int              stall_left = 0;

    always #2 aclk = ~aclk;

    text_console_cursor_engine #(
        .LINE_WIDTH    (LINE_WIDTH),
        .SCREEN_CELLS  (SCREEN_CELLS),
        .CONSOLES      (CONSOLES),
        .CONSOLE_CELLS (CONSOLE_CELLS)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_console_index (s_console_index),
        .s_char_code     (s_char_code),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_mem_write     (m_mem_write),
        .m_mem_addr      (m_mem_addr),
        .m_mem_char      (m_mem_char),
        .m_mem_attr      (m_mem_attr),
        .m_cursor_pos    (m_cursor_pos),
        .m_view_start    (m_view_start),
        .m_is_current    (m_is_current)
    );

    // Most gaps and stalls are short, a few are long enough to back up the queue.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Applies one request to the shadow state and returns the beat the engine should send.
    function automatic console_update_t predict_console_update(input logic [1:0] req,
                                                               input logic [1:0] con,
                                                               input logic [7:0] code);
        console_update_t upd;
        int              base;
        int              lim;
        int              cur;
        upd = '0;
        // A console beyond the configured count is ignored and reports all zeros.
        if (int'(con) >= CONSOLES) return upd;
        base = int'(con) * CONSOLE_CELLS;
        lim  = base + CONSOLE_CELLS;
        case (req)
            REQ_PUT: begin
                cur = cursor_tbl[con];
                if (code == CHAR_NEWLINE) begin
                    // Nothing happens on the last line of the slice.
                    if (cur + LINE_WIDTH < lim)
                        cursor_tbl[con] = base + ((cur - base) / LINE_WIDTH + 1) * LINE_WIDTH;
                end else if (code == CHAR_BACKSPACE) begin
                    // At the slice base the backspace neither moves nor writes.
                    if (cur > base) begin
                        cur--;
                        cursor_tbl[con] = cur;
                        upd.mem_write = 1'b1;
                        upd.mem_addr  = cur[ADDR_W-1:0];
                        upd.mem_char  = CHAR_SPACE;
                        upd.mem_attr  = attr_reg;
                    end
                end else if (cur + 1 < lim) begin
                    // The last cell of the slice is never written by a glyph.
                    upd.mem_write = 1'b1;
                    upd.mem_addr  = cur[ADDR_W-1:0];
                    upd.mem_char  = code;
                    upd.mem_attr  = attr_reg;
                    cursor_tbl[con] = cur + 1;
                end
                // The view chases the cursor one line at a time, bounded by the slice end.
                while (cursor_tbl[con] >= view_tbl[con] + SCREEN_CELLS &&
                       view_tbl[con] + SCREEN_CELLS < lim)
                    view_tbl[con] += LINE_WIDTH;
            end
            REQ_SCROLL_UP: begin
                if (view_tbl[con] > base) view_tbl[con] -= LINE_WIDTH;
            end
            REQ_SCROLL_DOWN: begin
                if (view_tbl[con] + SCREEN_CELLS < lim) view_tbl[con] += LINE_WIDTH;
            end
            default: begin
                shown_console = int'(con);
            end
        endcase
        cur = cursor_tbl[con];
        upd.cursor_pos = cur[ADDR_W-1:0];
        cur = view_tbl[con];
        upd.view_start = cur[ADDR_W-1:0];
        upd.is_current = (int'(con) == shown_console);
        return upd;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Sends one request beat after a random gap. Valid stays high into the next call
    // when that call draws no gap, so back-to-back beats keep valid asserted.
    task automatic send_request(input logic [1:0] req, input logic [1:0] con,
                                input logic [7:0] code);
        int gap;
        gap = idle_enable ? pick_gap() : 0;
        if (gap > 0 && s_valid) begin
            @(negedge aclk);
            s_valid = 1'b0;
            gap--;
        end
        repeat (gap) @(negedge aclk);
        @(negedge aclk);
        s_valid         = 1'b1;
        s_req_type      = req;
        s_console_index = con;
        s_char_code     = code;
        do @(posedge aclk); while (!s_ready);
        pending_updates.push_back(predict_console_update(req, con, code));
    endtask

    // Stops sending and waits until every predicted beat has come back, then lets
    // the engine settle so it is idle for a register write or the end of the run.
    task automatic drain_updates();
        if (s_valid) begin
            @(negedge aclk);
            s_valid = 1'b0;
        end
        while (pending_updates.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes the attribute register. Only called while the engine is idle.
    task automatic write_attr(input logic [7:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        attr_reg = value;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Boundary behavior from the reset state, with the reset attribute still in place.
    task automatic test_directed_edges();
        send_request(REQ_PUT, 2'd0, 8'h41);
        send_request(REQ_PUT, 2'd0, CHAR_BACKSPACE);
        // Second backspace sits at the slice base and must do nothing.
        send_request(REQ_PUT, 2'd0, CHAR_BACKSPACE);
        send_request(REQ_PUT, 2'd1, 8'h00);
        send_request(REQ_PUT, 2'd1, 8'hFF);
        send_request(REQ_PUT, 2'd1, CHAR_NEWLINE);
        send_request(REQ_PUT, 2'd2, CHAR_NEWLINE);
        send_request(REQ_PUT, 2'd0, 8'h61);
        send_request(REQ_PUT, 2'd0, CHAR_NEWLINE);
        // Scroll up at the top of the slice is refused, then the view goes down two lines and back up one.
        send_request(REQ_SCROLL_UP, 2'd3, 8'h00);
        send_request(REQ_SCROLL_DOWN, 2'd3, 8'hFF);
        send_request(REQ_SCROLL_DOWN, 2'd3, 8'h55);
        send_request(REQ_SCROLL_UP, 2'd3, 8'hAA);
        send_request(REQ_SELECT, 2'd2, 8'h00);
        send_request(REQ_PUT, 2'd2, 8'h78);
        send_request(REQ_SELECT, 2'd3, 8'hFF);
        send_request(REQ_PUT, 2'd3, 8'h7E);
        send_request(REQ_SELECT, 2'd0, 8'h00);
    endtask

    // The attribute register at both ends of its range.
    task automatic test_attr_extremes();
        drain_updates();
        write_attr(8'h00);
        send_request(REQ_PUT, 2'd1, 8'h30);
        send_request(REQ_PUT, 2'd1, CHAR_BACKSPACE);
        drain_updates();
        write_attr(8'hFF);
        send_request(REQ_PUT, 2'd2, 8'h31);
        send_request(REQ_PUT, 2'd2, CHAR_BACKSPACE);
    endtask

    // One burst of related requests, to one console unless it is noise. Long newline runs
    // and scroll runs drive the cursor and the view to the slice limits; noise mixes everything.
    task automatic run_burst(inout int sent);
        logic [1:0] con;
        logic [1:0] req;
        logic [7:0] code;
        int         kind;
        int         len;
        int         roll;
        logic [1:0] scroll_dir;
        con        = 2'($urandom_range(0, 3));
        kind       = $urandom_range(0, 9);
        scroll_dir = $urandom_range(0, 1) ? REQ_SCROLL_UP : REQ_SCROLL_DOWN;
        len        = (kind == 4 || kind == 5 || kind == 7) ? $urandom_range(10, 60)
                                                           : $urandom_range(1, 20);
        for (int i = 0; i < len; i++) begin
            roll = $urandom_range(0, 99);
            req  = REQ_PUT;
            code = 8'($urandom_range(0, 255));
            case (kind)
                0, 1, 2, 3: begin
                    if (roll >= 92) code = CHAR_BACKSPACE;
                    else if (roll >= 80) code = CHAR_NEWLINE;
                end
                4, 5: begin
                    if (roll < 75) code = CHAR_NEWLINE;
                end
                6: begin
                    if (roll < 80) code = CHAR_BACKSPACE;
                end
                7: begin
                    if (roll < 85) req = scroll_dir;
                    else if (roll < 92) req = (scroll_dir == REQ_SCROLL_UP) ? REQ_SCROLL_DOWN
                                                                            : REQ_SCROLL_UP;
                end
                8: begin
                    if (i == 0) req = REQ_SELECT;
                end
                default: begin
                    req = 2'($urandom_range(0, 3));
                    con = 2'($urandom_range(0, 3));
                end
            endcase
            send_request(req, con, code);
            sent++;
        end
    endtask

    // Random traffic in four phases with a new attribute each time. The second phase
    // runs with no idling on either side; every phase boundary waits for all results.
    task automatic test_random_traffic();
        int sent;
        for (int phase = 0; phase < 4; phase++) begin
            drain_updates();
            write_attr(phase == 0 ? 8'h07 : 8'($urandom_range(0, 255)));
            idle_enable = (phase != 1);
            sent = 0;
            while (sent < 300) begin
                run_burst(sent);
                // Now and then the sender holds off until the engine has answered everything.
                if (phase == 2 && $urandom_range(0, 19) == 0) drain_updates();
            end
        end
        idle_enable = 1'b1;
    endtask

    // The receiver stalls at random; stalls that are under way finish even when idling is off.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready = 1'b0;
            stall_left--;
        end else begin
            m_ready = 1'b1;
            if (idle_enable && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    // Every result beat is matched against the oldest prediction.
    always @(posedge aclk) begin : check_beat
        console_update_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_updates.size() == 0) begin
                $error("result beat arrived with no request outstanding");
                fail_count++;
            end else begin
                want = pending_updates.pop_front();
                check_field("mem_write", want.mem_write, m_mem_write);
                check_field("mem_addr", want.mem_addr, m_mem_addr);
                check_field("mem_char", want.mem_char, m_mem_char);
                check_field("mem_attr", want.mem_attr, m_mem_attr);
                check_field("cursor_pos", want.cursor_pos, m_cursor_pos);
                check_field("view_start", want.view_start, m_view_start);
                check_field("is_current", want.is_current, m_is_current);
            end
        end
    end

    initial begin
        // The shadow state starts where the engine's reset puts it.
        for (int i = 0; i < SLOTS; i++) begin
            cursor_tbl[i] = i * CONSOLE_CELLS;
            view_tbl[i]   = i * CONSOLE_CELLS;
        end
        shown_console = 0;
        attr_reg      = ATTR_RESET;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed_edges();
        test_attr_extremes();
        test_random_traffic();
        drain_updates();

        if (pending_updates.size() != 0) begin
            $error("%0d predicted results never arrived", pending_updates.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog: far longer than the slowest correct run of this stimulus.
    initial begin
        #3ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tcc_pkg.sv
rtl/tcc_front.sv
rtl/tcc_queue.sv
rtl/tcc_back.sv
rtl/text_console_cursor_engine.sv
test/tb_top.sv
